>>> hdl/wis_pkg.sv
package wis_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned PROFIT_W = 16;
    localparam int unsigned TOTAL_W  = 22;
    localparam int unsigned JOB_W    = 2 * TIME_W + PROFIT_W;

    typedef struct packed {
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   end_time;
        logic [PROFIT_W-1:0] job_profit;
        logic                last_job;
    } t_job_in;

    typedef struct packed {
        logic [TOTAL_W-1:0] max_profit;
        logic               dropped;
    } t_result;

endpackage

>>> hdl/weighted_interval_scheduling.sv
// Weighted interval scheduling engine.
// Input: a job beat (start, end, profit, last flag) is taken when start is
// high and busy is low. Each job is insertion-sorted into the job memory by
// end time, then start time; equal jobs keep arrival order. Insertion reads
// and shifts one stored entry up at a time (states IRD, ICMP), so busy stays
// high after the beat while the stored jobs that move up are shifted and the
// new job is written. A job arriving with the store full is dropped and flagged.
// On the last job the dynamic program runs: for each sorted job i the
// predecessor search walks back from i one memory read at a time (states
// DRDJ, DCMPJ), then, if a predecessor is found, reads its best-table entry.
// Result: o_valid pulses for one cycle with the best total (saturated to 22
// bits) and the drop flag; the receiver cannot stall, nothing is held.
// After a result the job set is empty again.
// Reset (synchronous, active low) empties the job set and returns to idle;
// memory contents are not cleared and are read only below the job count.
module weighted_interval_scheduling #(
    parameter int unsigned MAX_JOBS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  wis_pkg::t_job_in  i_job,
    output logic              o_valid,
    output wis_pkg::t_result  o_result
);
    import wis_pkg::*;

    localparam int unsigned AW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int unsigned CW  = $clog2(MAX_JOBS + 1);
    localparam int unsigned BAW = $clog2(MAX_JOBS + 1);
    localparam int unsigned BW  = TOTAL_W + 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_JOBS);
    localparam logic [BW-1:0] SAT  = {1'b0, {TOTAL_W{1'b1}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IRD   = 4'd1;
    localparam logic [3:0] S_ICMP  = 4'd2;
    localparam logic [3:0] S_DINIT = 4'd3;
    localparam logic [3:0] S_DRDI  = 4'd4;
    localparam logic [3:0] S_DGETI = 4'd5;
    localparam logic [3:0] S_DRDJ  = 4'd6;
    localparam logic [3:0] S_DCMPJ = 4'd7;
    localparam logic [3:0] S_DRDB  = 4'd8;
    localparam logic [3:0] S_DFIN  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_last, n_last;
    logic [TIME_W-1:0]   r_st, n_st;
    logic [TIME_W-1:0]   r_en, n_en;
    logic [PROFIT_W-1:0] r_pr, n_pr;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [BW-1:0]       r_v, n_v;
    logic                r_hit, n_hit;
    logic                r_ov, n_ov;

    logic             j_we;
    logic [AW-1:0]    j_wa, j_ra;
    logic [JOB_W-1:0] j_wd, j_rd;
    logic             b_we;
    logic [BAW-1:0]   b_wa, b_ra;
    logic [BW-1:0]    b_wd, b_rd;

    logic [TIME_W-1:0]   rd_st, rd_en;
    logic [PROFIT_W-1:0] rd_pr;
    logic                stop_ins;
    logic [BW-1:0]       cand;

    assign rd_st = j_rd[JOB_W-1 -: TIME_W];
    assign rd_en = j_rd[PROFIT_W +: TIME_W];
    assign rd_pr = j_rd[PROFIT_W-1:0];
    assign stop_ins = (rd_en < r_en) || ((rd_en == r_en) && (rd_st <= r_st));
    assign cand = BW'(r_pr) + b_rd;

    wis_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_jobs (
        .i_clk(i_clk), .i_we(j_we), .i_waddr(j_wa), .i_wdata(j_wd),
        .i_raddr(j_ra), .o_rdata(j_rd)
    );

    wis_ram #(.WIDTH(BW), .DEPTH(MAX_JOBS + 1)) u_best (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(b_ra), .o_rdata(b_rd)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_last  = r_last;
        n_st    = r_st;
        n_en    = r_en;
        n_pr    = r_pr;
        n_pos   = r_pos;
        n_i     = r_i;
        n_j     = r_j;
        n_v     = r_v;
        n_hit   = r_hit;
        n_ov    = r_ov;
        j_we = 1'b0;
        j_wa = '0;
        j_wd = {r_st, r_en, r_pr};
        j_ra = '0;
        b_we = 1'b0;
        b_wa = '0;
        b_wd = r_v;
        b_ra = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_st   = i_job.start_time;
                    n_en   = i_job.end_time;
                    n_pr   = i_job.job_profit;
                    n_last = i_job.last_job;
                    n_pos  = r_count;
                    if (r_count == FULL) begin
                        n_ovf   = 1'b1;
                        n_state = i_job.last_job ? S_DINIT : S_IDLE;
                    end else begin
                        n_state = S_IRD;
                    end
                end
            end
            S_IRD: begin
                if (r_pos == '0) begin
                    j_we    = 1'b1;
                    j_wa    = '0;
                    n_count = r_count + 1'b1;
                    n_state = r_last ? S_DINIT : S_IDLE;
                end else begin
                    j_ra    = AW'(r_pos - 1'b1);
                    n_state = S_ICMP;
                end
            end
            S_ICMP: begin
                j_we = 1'b1;
                j_wa = AW'(r_pos);
                if (stop_ins) begin
                    n_count = r_count + 1'b1;
                    n_state = r_last ? S_DINIT : S_IDLE;
                end else begin
                    j_wd    = j_rd;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_IRD;
                end
            end
            S_DINIT: begin
                b_we    = 1'b1;
                b_wa    = '0;
                b_wd    = '0;
                n_i     = '0;
                n_ov    = 1'b0;
                n_state = (r_count == '0) ? S_DFIN : S_DRDI;
            end
            S_DRDI: begin
                j_ra    = AW'(r_i);
                b_ra    = BAW'(r_i);
                n_state = S_DGETI;
            end
            S_DGETI: begin
                n_st    = rd_st;
                n_pr    = rd_pr;
                n_v     = (BW'(rd_pr) > b_rd) ? BW'(rd_pr) : b_rd;
                n_j     = r_i;
                n_hit   = 1'b0;
                n_state = (r_i == '0) ? S_DRDB : S_DRDJ;
            end
            S_DRDJ: begin
                j_ra    = AW'(r_j - 1'b1);
                n_state = S_DCMPJ;
            end
            S_DCMPJ: begin
                if (rd_en <= r_st) begin
                    n_hit   = 1'b1;
                    n_state = S_DRDB;
                end else begin
                    n_j     = r_j - 1'b1;
                    n_state = (r_j == CW'(1)) ? S_DRDB : S_DRDJ;
                end
            end
            S_DRDB: begin
                b_ra    = BAW'(r_j);
                n_state = S_DFIN;
                if (!r_hit) begin
                    b_we    = 1'b1;
                    b_wa    = BAW'(r_i + 1'b1);
                    n_i     = r_i + 1'b1;
                    n_state = (r_i + 1'b1 == r_count) ? S_OUT : S_DRDI;
                    if (r_v[BW-1]) begin
                        n_ov = 1'b1;
                    end
                end
            end
            S_DFIN: begin
                if (r_count == '0) begin
                    n_state = S_OUT;
                end else begin
                    b_we = 1'b1;
                    b_wa = BAW'(r_i + 1'b1);
                    b_wd = (cand > r_v) ? cand : r_v;
                    if (b_wd > SAT) begin
                        b_wd = SAT;
                    end
                    n_v  = b_wd;
                    n_i  = r_i + 1'b1;
                    n_state = (r_i + 1'b1 == r_count) ? S_OUT : S_DRDI;
                end
            end
            S_OUT: begin
                n_count = '0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_DINIT) begin
            n_v = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
        r_last  <= n_last;
        r_st    <= n_st;
        r_en    <= n_en;
        r_pr    <= n_pr;
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_j     <= n_j;
        r_v     <= n_v;
        r_hit   <= n_hit;
        r_ov    <= n_ov;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = (r_state == S_OUT);
    assign o_result.max_profit = (r_count == '0) ? '0 :
                                 ((r_v[BW-1] || r_ov) ? '1 : r_v[TOTAL_W-1:0]);
    assign o_result.dropped    = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL) else $error("job count past capacity");
    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (r_count == '0 && !r_ovf && !o_valid))
        else $error("job set not cleared after result");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !j_we) else $error("job write while idle");

endmodule

>>> hdl/wis_ram.sv
module wis_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
